// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// clocked concurrent checks with reset gating
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

// ----- rtl/irc_pkg.sv -----
// ----------------------------------------------------------------------------
// irc_pkg
// shared constants and types of the address range country lookup
// ----------------------------------------------------------------------------
package irc_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);

    typedef enum logic [1:0] {
        FN_LOOKUP = 2'd0,
        FN_INSERT = 2'd1,
        FN_CLEAR  = 2'd2
    } t_func;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] last;
        logic [7:0]  country;
    } t_entry;

    typedef struct packed {
        logic        any;
        logic        hit;
        logic        eq;
        logic [7:0]  country;
    } t_link;

    typedef struct packed {
        logic        shift;
        logic        update;
        logic [31:0] key;
        logic [31:0] last;
        logic [7:0]  country;
    } t_cell_ctl;

endpackage

// ----- rtl/irc_ifs.sv -----
// ----------------------------------------------------------------------------
// irc interfaces
// valid/ready channels for input words, result words and configuration
// ----------------------------------------------------------------------------
interface irc_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] address;
    logic [31:0] range_end;
    logic [7:0]  country_id;

    modport source (output valid, func, address, range_end, country_id, input ready);
    modport sink   (input valid, func, address, range_end, country_id, output ready);
endinterface

interface irc_res_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [7:0]  result_country;
    logic        status;

    modport source (output valid, found, result_country, status, input ready);
    modport sink   (input valid, found, result_country, status, output ready);
endinterface

interface irc_cfg_if;
    logic valid;
    logic ready;
    logic lookup_enable;

    modport source (output valid, lookup_enable, input ready);
    modport sink   (input valid, lookup_enable, output ready);
endinterface

// ----- rtl/irc_cell.sv -----
// ----------------------------------------------------------------------------
// irc_cell
// one table entry: compares against the key, shifts on insert, and passes
// the result word along the chain
// ----------------------------------------------------------------------------
module irc_cell import irc_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_valid,
    input  logic      i_le_prev,
    input  logic      i_le_next,
    input  t_entry    i_left,
    output t_entry    o_entry,
    output logic      o_le,
    input  t_link     i_link,
    output t_link     o_link
);

    t_entry r_entry;
    t_link  r_link;
    t_link  n_link;
    logic   w_le;
    logic   w_sel;

    assign w_le  = i_valid && (r_entry.start <= i_ctl.key);
    assign w_sel = w_le && !i_le_next;

    always_comb begin
        if (w_sel) begin
            n_link.any     = 1'b1;
            n_link.hit     = (i_ctl.key <= r_entry.last);
            n_link.eq      = (r_entry.start == i_ctl.key);
            n_link.country = r_entry.country;
        end else begin
            n_link = i_link;
        end
    end

    always_ff @(posedge i_clk) begin
        r_link <= n_link;
        if (i_ctl.shift && !w_le) begin
            if (i_le_prev) begin
                r_entry.start   <= i_ctl.key;
                r_entry.last    <= i_ctl.last;
                r_entry.country <= i_ctl.country;
            end else begin
                r_entry <= i_left;
            end
        end else if (i_ctl.update && w_sel) begin
            r_entry.last    <= i_ctl.last;
            r_entry.country <= i_ctl.country;
        end
    end

    assign o_entry = r_entry;
    assign o_le    = w_le;
    assign o_link  = r_link;

endmodule

// ----- rtl/irc_ctrl.sv -----
// ----------------------------------------------------------------------------
// irc_ctrl
// sequencer: takes input words, runs the chain walk, applies inserts and
// holds the result word
// ----------------------------------------------------------------------------
module irc_ctrl import irc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    irc_item_if.sink         i_item,
    irc_res_if.source        o_result,
    irc_cfg_if.sink          i_cfg,
    input  t_link            i_tail,
    output t_cell_ctl        o_ctl,
    output logic [CNT_W-1:0] o_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_APPLY,
        S_DONE
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_walk;
    logic [CNT_W-1:0] r_count;
    logic             r_enable;
    logic             r_lookup;
    logic [31:0]      r_key;
    logic [31:0]      r_last;
    logic [7:0]       r_country;
    logic             r_found;
    logic [7:0]       r_rcountry;
    logic             r_status;
    logic             r_shift;
    logic             r_update;
    logic             r_out_valid;
    logic             r_out_found;
    logic [7:0]       r_out_country;
    logic             r_out_status;

    logic             w_accept;
    logic             w_short;
    logic             w_hit;
    logic [31:0]      n_key;

    assign i_item.ready = (r_state == S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign w_accept     = i_item.valid && i_item.ready;
    assign w_short      = !r_enable || (i_item.address == 32'd0) || (r_count == '0);
    assign w_hit        = i_tail.any && i_tail.hit;

    // network order to host order for lookups
    assign n_key = (i_item.func == FN_LOOKUP)
                 ? {i_item.address[7:0], i_item.address[15:8],
                    i_item.address[23:16], i_item.address[31:24]}
                 : i_item.address;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_enable    <= 1'b0;
            r_shift     <= 1'b0;
            r_update    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_shift  <= 1'b0;
            r_update <= 1'b0;
            if (i_cfg.valid && i_cfg.ready) begin
                r_enable <= i_cfg.lookup_enable;
            end
            if (o_result.valid && o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_shift) begin
                r_count <= r_count + 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_key      <= n_key;
                        r_last     <= i_item.range_end;
                        r_country  <= i_item.country_id;
                        r_lookup   <= (i_item.func == FN_LOOKUP);
                        r_found    <= 1'b0;
                        r_rcountry <= '0;
                        r_status   <= 1'b0;
                        r_walk     <= '0;
                        unique case (i_item.func)
                            FN_LOOKUP: r_state <= w_short ? S_DONE : S_WALK;
                            FN_INSERT: r_state <= S_WALK;
                            FN_CLEAR: begin
                                r_count <= '0;
                                r_state <= S_DONE;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_WALK: begin
                    r_walk <= r_walk + 1'b1;
                    if (r_walk == IDX_W'(TABLE_ENTRIES - 1)) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    priority if (r_lookup) begin
                        r_found    <= w_hit;
                        r_rcountry <= w_hit ? i_tail.country : 8'd0;
                    end else if (i_tail.any && i_tail.eq) begin
                        r_update <= 1'b1;
                    end else if (r_count == CNT_W'(TABLE_ENTRIES)) begin
                        r_status <= 1'b1;
                    end else begin
                        r_shift <= 1'b1;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid   <= 1'b1;
                        r_out_found   <= r_found;
                        r_out_country <= r_rcountry;
                        r_out_status  <= r_status;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ctl.shift   = r_shift;
    assign o_ctl.update  = r_update;
    assign o_ctl.key     = r_key;
    assign o_ctl.last    = r_last;
    assign o_ctl.country = r_country;
    assign o_count       = r_count;

    assign o_result.valid          = r_out_valid;
    assign o_result.found          = r_out_found;
    assign o_result.result_country = r_out_country;
    assign o_result.status         = r_out_status;

endmodule

// ----- rtl/ip_range_country_lookup_core.sv -----
// ----------------------------------------------------------------------------
// ip_range_country_lookup_core
// lookup and insert: walk, apply and done states, then the result word
// clear, unused codes and disabled, zero or empty lookups skip walk and apply
// throughput: one word at a time, set by the result walk down the cell chain
// reset: control, entry count and enable clear; cell contents are left as they are
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ip_range_country_lookup_core import irc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    irc_item_if.sink  i_item,
    irc_res_if.source o_result,
    irc_cfg_if.sink   i_cfg
);

    t_cell_ctl        w_ctl;
    logic [CNT_W-1:0] w_count;
    t_entry           w_entry [TABLE_ENTRIES];
    t_link            w_link  [TABLE_ENTRIES];
    logic             w_le    [TABLE_ENTRIES];
    logic             w_valid [TABLE_ENTRIES];

    irc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .o_result (o_result),
        .i_cfg    (i_cfg),
        .i_tail   (w_link[TABLE_ENTRIES-1]),
        .o_ctl    (w_ctl),
        .o_count  (w_count)
    );

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        logic   w_le_prev;
        logic   w_le_next;
        t_entry w_left;
        t_link  w_link_in;

        assign w_valid[g] = (w_count > CNT_W'(g));

        if (g == 0) begin : g_head
            assign w_le_prev = 1'b1;
            assign w_left    = w_entry[0];
            assign w_link_in = '0;
        end else begin : g_body
            assign w_le_prev = w_le[g-1];
            assign w_left    = w_entry[g-1];
            assign w_link_in = w_link[g-1];
        end

        if (g == TABLE_ENTRIES - 1) begin : g_tail
            assign w_le_next = 1'b0;
        end else begin : g_mid
            assign w_le_next = w_le[g+1];
        end

        irc_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_valid   (w_valid[g]),
            .i_le_prev (w_le_prev),
            .i_le_next (w_le_next),
            .i_left    (w_left),
            .o_entry   (w_entry[g]),
            .o_le      (w_le[g]),
            .i_link    (w_link_in),
            .o_link    (w_link[g])
        );
    end

    `ASSERT_CLK(a_count_bound, w_count <= CNT_W'(TABLE_ENTRIES), "entry count above table size")
    `ASSERT_NEVER(a_cmd_excl, w_ctl.shift && w_ctl.update, "shift and update together")
    `ASSERT_CLK(a_shift_count, w_ctl.shift |=> w_count == CNT_W'($past(w_count) + 1'b1), "shift without count step")
    `ASSERT_CLK(a_miss_zero, o_result.valid && !o_result.found |-> o_result.result_country == 8'd0, "miss with nonzero country")
    `ASSERT_CLK(a_hit_ok, o_result.valid && o_result.found |-> !o_result.status, "hit with full status")

endmodule
